FILE: hdl/assert_macros.svh
// Assertion macros used by the pose integrator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising edge of clk outside reset
`define AST_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) else $error(msg);

// next-cycle implication
`define AST_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) else $error(msg);

`endif

FILE: hdl/imupi_pkg.sv
// Package for the IMU pose integrator: sequencer states, constants and saturating helpers.
`timescale 1ns / 1ps
`default_nettype none
package imupi_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DT_BITS       = 24;

  localparam logic signed [63:0] Q_ONE64 = 64'sd1073741824;
  localparam logic signed [31:0] Q_ONE   = 32'sd1073741824;
  localparam logic signed [63:0] ONE60   = 64'sd1 <<< 60;

  localparam logic [2:0] REG_GYRO_BIAS_X  = 3'd0;
  localparam logic [2:0] REG_GYRO_BIAS_Y  = 3'd1;
  localparam logic [2:0] REG_GYRO_BIAS_Z  = 3'd2;
  localparam logic [2:0] REG_ACCEL_BIAS_X = 3'd3;
  localparam logic [2:0] REG_ACCEL_BIAS_Y = 3'd4;
  localparam logic [2:0] REG_ACCEL_BIAS_Z = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RQ,
    S_RMAT,
    S_RACC,
    S_DT2,
    S_KIN,
    S_QMUL,
    S_NMAX,
    S_NSHIFT,
    S_NSQ,
    S_NCHK,
    S_SQRT,
    S_DIV,
    S_FIN,
    S_OUT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v > 64'sd140737488355327) begin
      return 48'sh7fffffffffff;
    end else if (v < -64'sd140737488355328) begin
      return 48'sh800000000000;
    end else begin
      return v[47:0];
    end
  endfunction

  function automatic logic signed [31:0] clampq(input logic signed [63:0] v);
    if (v > Q_ONE64) begin
      return Q_ONE;
    end else if (v < -Q_ONE64) begin
      return -Q_ONE;
    end else begin
      return v[31:0];
    end
  endfunction

  // round half up, arithmetic shift
  function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                              input int unsigned s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/imu_midpoint_pose_integrator.sv
// Strapdown IMU pose integrator, midpoint rule, fixed point.
// Input channel: in_valid / in_stall carries one IMU sample (biased gyro and
// accelerometer, step_time in Q0.24 s); a transfer happens when in_valid is
// high and in_stall low. Output channel: out_valid / out_stall carries the
// pose after that sample (quaternion Q2.30, position, velocity).
// The user must write the biases through wr_en / wr_index / wr_data only
// while idle; the block itself does not enforce this. All products go
// through one shift-add multiplier that retires one multiplier bit per
// cycle; square root and the four normalising divisions are bit-serial as
// well. The first sample after reset takes 18 products; every later sample
// takes 47 products, up to 33 normalising shifts, a 32-step root and four
// 62-step divisions (no root or division when the sum of squares is zero).
// One sample at a time. in_stall is high from the transfer until the result
// is in the output register; a waiting result does not block the next
// transfer. Reset (rst, synchronous): identity orientation, zero pose, zero
// biases, unprimed. A stalled output holds its payload and the block waits
// in its last step until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module imu_midpoint_pose_integrator #(
  parameter int FRAC_BITS = imupi_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [31:0]        wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] gyro_x,
  input  logic signed [31:0] gyro_y,
  input  logic signed [31:0] gyro_z,
  input  logic signed [31:0] accel_x,
  input  logic signed [31:0] accel_y,
  input  logic signed [31:0] accel_z,
  input  logic [23:0]        step_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] quat_w,
  output logic signed [31:0] quat_x,
  output logic signed [31:0] quat_y,
  output logic signed [31:0] quat_z,
  output logic signed [47:0] pos_x,
  output logic signed [47:0] pos_y,
  output logic signed [47:0] pos_z,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic signed [31:0] vel_z
);

  localparam logic signed [63:0] G_MAG =
    ((64'sd981 <<< FRAC_BITS) + 64'sd50) / 64'sd100;
  localparam int unsigned DA_SHIFT = FRAC_BITS - 5;

  imupi_pkg::state_t state, state_next;

  // configuration and pose state
  logic signed [31:0] gbias [3];
  logic signed [31:0] abias [3];
  logic signed [31:0] q [4];
  logic signed [47:0] pos [3];
  logic signed [31:0] vel [3];
  logic signed [31:0] pwacc [3];
  logic signed [31:0] prate [3];
  logic               primed;

  // per-sample working registers
  logic signed [31:0] rate_r [3];
  logic signed [31:0] acc_r [3];
  logic [23:0]        dt_r;
  logic [24:0]        dt2;
  logic signed [63:0] qp [9];
  logic signed [31:0] rm [9];
  logic signed [31:0] wacc [3];
  logic signed [35:0] wsum;
  logic signed [32:0] kterm;
  logic signed [31:0] da [3];
  logic signed [63:0] p [4];
  logic [63:0]        mabs;
  logic [63:0]        ss;
  logic [63:0]        srem;
  logic [63:0]        sres;
  logic [63:0]        sbit;
  logic [61:0]        dn;
  logic [31:0]        drem;
  logic               dneg;

  // sequencer counters
  logic [3:0] idx;
  logic [1:0] row;
  logic [1:0] col;
  logic [5:0] cnt;
  logic       pend;

  // shift-add multiplier
  logic               mul_go;
  logic               mul_run;
  logic               mul_fin;
  logic [4:0]         mcnt;
  logic [31:0]        mamag;
  logic [31:0]        mb;
  logic               mneg;
  logic [63:0]        macc;
  logic [32:0]        msum;
  logic signed [63:0] prod;
  logic signed [31:0] op_a;
  logic signed [31:0] op_b;
  logic [1:0]         p_tgt;

  logic               in_take;
  logic               out_free;
  logic signed [31:0] gyro_v [3];
  logic signed [31:0] accel_v [3];
  logic signed [32:0] ma_sum;
  logic signed [32:0] mr_sum;
  logic signed [31:0] ma_sel;
  logic signed [31:0] mr_sel;
  logic signed [31:0] dt_op;
  logic signed [31:0] dt2_op;
  logic [63:0]        sq_try;
  logic [32:0]        d_try;
  logic signed [31:0] c_div;

  assign gyro_v  = '{gyro_x, gyro_y, gyro_z};
  assign accel_v = '{accel_x, accel_y, accel_z};
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign ma_sum = 33'(pwacc[row]) + 33'(wacc[row]);
  assign mr_sum = 33'(prate[row]) + 33'(rate_r[row]);
  assign ma_sel = ma_sum[32:1];
  assign mr_sel = mr_sum[32:1];
  assign dt_op  = $signed({8'd0, dt_r});
  assign dt2_op = $signed({7'd0, dt2});

  assign msum = {1'b0, macc[63:32]} + (mb[0] ? {1'b0, mamag} : 33'd0);
  assign prod = mneg ? -$signed(macc) : $signed(macc);

  assign sq_try = sres + sbit;
  assign d_try  = {drem, dn[61]};
  assign c_div  = p[idx[1:0]][31:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      imupi_pkg::S_IDLE:   if (in_take) state_next = imupi_pkg::S_RQ;
      imupi_pkg::S_RQ:     if (mul_fin && idx == 4'd8) state_next = imupi_pkg::S_RMAT;
      imupi_pkg::S_RMAT:   state_next = imupi_pkg::S_RACC;
      imupi_pkg::S_RACC: begin
        if (mul_fin && idx == 4'd8) begin
          state_next = primed ? imupi_pkg::S_DT2 : imupi_pkg::S_FIN;
        end
      end
      imupi_pkg::S_DT2:    if (mul_fin) state_next = imupi_pkg::S_KIN;
      imupi_pkg::S_KIN: begin
        if (mul_fin && row == 2'd2 && col == 2'd3) state_next = imupi_pkg::S_QMUL;
      end
      imupi_pkg::S_QMUL:   if (mul_fin && idx == 4'd11) state_next = imupi_pkg::S_NMAX;
      imupi_pkg::S_NMAX:   if (idx == 4'd3) state_next = imupi_pkg::S_NSHIFT;
      imupi_pkg::S_NSHIFT: if (mabs[63:31] == '0) state_next = imupi_pkg::S_NSQ;
      imupi_pkg::S_NSQ:    if (mul_fin && idx == 4'd3) state_next = imupi_pkg::S_NCHK;
      imupi_pkg::S_NCHK: begin
        state_next = (ss == '0) ? imupi_pkg::S_FIN : imupi_pkg::S_SQRT;
      end
      imupi_pkg::S_SQRT:   if (cnt == 6'd31) state_next = imupi_pkg::S_DIV;
      imupi_pkg::S_DIV: begin
        if (pend && cnt == 6'd62 && idx == 4'd3) state_next = imupi_pkg::S_FIN;
      end
      imupi_pkg::S_FIN:    state_next = imupi_pkg::S_OUT;
      imupi_pkg::S_OUT:    if (out_free) state_next = imupi_pkg::S_IDLE;
      default:             state_next = imupi_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake, multiplier start and operands
  always_comb begin
    in_stall = (state != imupi_pkg::S_IDLE);
    mul_go   = 1'b0;
    op_a     = '0;
    op_b     = '0;
    p_tgt    = '0;
    case (state)
      imupi_pkg::S_RQ: begin
        mul_go = !pend;
        case (idx)
          4'd0:    begin op_a = q[1]; op_b = q[1]; end
          4'd1:    begin op_a = q[2]; op_b = q[2]; end
          4'd2:    begin op_a = q[3]; op_b = q[3]; end
          4'd3:    begin op_a = q[1]; op_b = q[2]; end
          4'd4:    begin op_a = q[1]; op_b = q[3]; end
          4'd5:    begin op_a = q[2]; op_b = q[3]; end
          4'd6:    begin op_a = q[0]; op_b = q[1]; end
          4'd7:    begin op_a = q[0]; op_b = q[2]; end
          default: begin op_a = q[0]; op_b = q[3]; end
        endcase
      end
      imupi_pkg::S_RACC: begin
        mul_go = !pend;
        op_a   = rm[idx];
        op_b   = acc_r[col];
      end
      imupi_pkg::S_DT2: begin
        mul_go = !pend;
        op_a   = dt_op;
        op_b   = dt_op;
      end
      imupi_pkg::S_KIN: begin
        mul_go = !pend;
        case (col)
          2'd0:    begin op_a = dt_op;  op_b = vel[row]; end
          2'd1:    begin op_a = dt2_op; op_b = ma_sel;   end
          2'd2:    begin op_a = dt_op;  op_b = ma_sel;   end
          default: begin op_a = dt_op;  op_b = mr_sel;   end
        endcase
      end
      imupi_pkg::S_QMUL: begin
        // q * (1, da): negative terms carry the sign on the q operand
        mul_go = !pend;
        case (idx)
          4'd0:    begin op_a = -q[1]; op_b = da[0]; p_tgt = 2'd0; end
          4'd1:    begin op_a = -q[2]; op_b = da[1]; p_tgt = 2'd0; end
          4'd2:    begin op_a = -q[3]; op_b = da[2]; p_tgt = 2'd0; end
          4'd3:    begin op_a = q[0];  op_b = da[0]; p_tgt = 2'd1; end
          4'd4:    begin op_a = q[2];  op_b = da[2]; p_tgt = 2'd1; end
          4'd5:    begin op_a = -q[3]; op_b = da[1]; p_tgt = 2'd1; end
          4'd6:    begin op_a = q[0];  op_b = da[1]; p_tgt = 2'd2; end
          4'd7:    begin op_a = -q[1]; op_b = da[2]; p_tgt = 2'd2; end
          4'd8:    begin op_a = q[3];  op_b = da[0]; p_tgt = 2'd2; end
          4'd9:    begin op_a = q[0];  op_b = da[2]; p_tgt = 2'd3; end
          4'd10:   begin op_a = q[1];  op_b = da[1]; p_tgt = 2'd3; end
          default: begin op_a = -q[2]; op_b = da[0]; p_tgt = 2'd3; end
        endcase
      end
      imupi_pkg::S_NSQ: begin
        mul_go = !pend;
        op_a   = c_div;
        op_b   = c_div;
      end
      default: ;
    endcase
  end

  // multiplier: one bit of the multiplier magnitude per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_run <= 1'b0;
      mul_fin <= 1'b0;
    end else begin
      mul_fin <= 1'b0;
      if (mul_go) begin
        mamag   <= op_a[31] ? 32'(-op_a) : op_a;
        mb      <= op_b[31] ? 32'(-op_b) : op_b;
        mneg    <= op_a[31] ^ op_b[31];
        macc    <= '0;
        mcnt    <= '0;
        mul_run <= 1'b1;
      end else if (mul_run) begin
        macc <= {msum, macc[31:1]};
        mb   <= {1'b0, mb[31:1]};
        mcnt <= mcnt + 5'd1;
        if (mcnt == 5'd31) begin
          mul_run <= 1'b0;
          mul_fin <= 1'b1;
        end
      end
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= imupi_pkg::S_IDLE;
      pend   <= 1'b0;
      idx    <= '0;
      row    <= '0;
      col    <= '0;
      cnt    <= '0;
      primed <= 1'b0;
      out_valid <= 1'b0;
      q[0] <= imupi_pkg::Q_ONE;
      q[1] <= '0;
      q[2] <= '0;
      q[3] <= '0;
      for (int i = 0; i < 3; i++) begin
        gbias[i] <= '0;
        abias[i] <= '0;
        pos[i]   <= '0;
        vel[i]   <= '0;
        pwacc[i] <= '0;
        prate[i] <= '0;
      end
    end else begin
      state <= state_next;

      if (out_valid && !out_stall) out_valid <= 1'b0;

      if (wr_en) begin
        case (wr_index)
          imupi_pkg::REG_GYRO_BIAS_X:  gbias[0] <= wr_data;
          imupi_pkg::REG_GYRO_BIAS_Y:  gbias[1] <= wr_data;
          imupi_pkg::REG_GYRO_BIAS_Z:  gbias[2] <= wr_data;
          imupi_pkg::REG_ACCEL_BIAS_X: abias[0] <= wr_data;
          imupi_pkg::REG_ACCEL_BIAS_Y: abias[1] <= wr_data;
          imupi_pkg::REG_ACCEL_BIAS_Z: abias[2] <= wr_data;
          default: ;
        endcase
      end

      if (mul_go) pend <= 1'b1;
      if (mul_fin) pend <= 1'b0;

      case (state)
        imupi_pkg::S_IDLE: begin
          if (in_take) begin
            for (int i = 0; i < 3; i++) begin
              rate_r[i] <= imupi_pkg::sat32(64'(gyro_v[i]) - 64'(gbias[i]));
              acc_r[i]  <= imupi_pkg::sat32(64'(accel_v[i]) - 64'(abias[i]));
            end
            dt_r <= step_time;
          end
        end
        imupi_pkg::S_RQ: begin
          if (mul_fin) begin
            qp[idx] <= prod;
            idx     <= idx + 4'd1;
          end
        end
        imupi_pkg::S_RMAT: begin
          rm[0] <= imupi_pkg::clampq(imupi_pkg::rshr(
                     imupi_pkg::ONE60 - ((qp[1] + qp[2]) <<< 1), 30));
          rm[1] <= imupi_pkg::clampq(imupi_pkg::rshr((qp[3] - qp[8]) <<< 1, 30));
          rm[2] <= imupi_pkg::clampq(imupi_pkg::rshr((qp[4] + qp[7]) <<< 1, 30));
          rm[3] <= imupi_pkg::clampq(imupi_pkg::rshr((qp[3] + qp[8]) <<< 1, 30));
          rm[4] <= imupi_pkg::clampq(imupi_pkg::rshr(
                     imupi_pkg::ONE60 - ((qp[0] + qp[2]) <<< 1), 30));
          rm[5] <= imupi_pkg::clampq(imupi_pkg::rshr((qp[5] - qp[6]) <<< 1, 30));
          rm[6] <= imupi_pkg::clampq(imupi_pkg::rshr((qp[4] - qp[7]) <<< 1, 30));
          rm[7] <= imupi_pkg::clampq(imupi_pkg::rshr((qp[5] + qp[6]) <<< 1, 30));
          rm[8] <= imupi_pkg::clampq(imupi_pkg::rshr(
                     imupi_pkg::ONE60 - ((qp[0] + qp[1]) <<< 1), 30));
          wsum  <= '0;
        end
        imupi_pkg::S_RACC: begin
          if (mul_fin) begin
            logic signed [63:0] term;
            logic signed [35:0] wsum_n;
            term   = imupi_pkg::rshr(prod, 30);
            wsum_n = wsum + term[35:0];
            idx    <= idx + 4'd1;
            if (col == 2'd2) begin
              if (row == 2'd2) begin
                wacc[row] <= imupi_pkg::sat32(64'(wsum_n) + G_MAG);
              end else begin
                wacc[row] <= imupi_pkg::sat32(64'(wsum_n));
              end
              wsum <= '0;
              col  <= '0;
              row  <= row + 2'd1;
            end else begin
              wsum <= wsum_n;
              col  <= col + 2'd1;
            end
          end
        end
        imupi_pkg::S_DT2: begin
          for (int i = 0; i < 4; i++) p[i] <= 64'(q[i]) <<< 30;
          mabs <= '0;
          if (mul_fin) begin
            logic signed [63:0] t2;
            t2  = imupi_pkg::rshr(prod, imupi_pkg::DT_BITS);
            dt2 <= t2[24:0];
          end
        end
        imupi_pkg::S_KIN: begin
          if (mul_fin) begin
            logic signed [63:0] t;
            case (col)
              2'd0: begin
                t = imupi_pkg::rshr(prod, imupi_pkg::DT_BITS);
                kterm <= t[32:0];
              end
              2'd1: begin
                pos[row] <= imupi_pkg::sat48(64'(pos[row]) + 64'(kterm)
                                             + imupi_pkg::rshr(prod, imupi_pkg::DT_BITS + 1));
              end
              2'd2: begin
                vel[row] <= imupi_pkg::sat32(64'(vel[row])
                                             + imupi_pkg::rshr(prod, imupi_pkg::DT_BITS));
              end
              default: begin
                da[row] <= imupi_pkg::sat32(imupi_pkg::rshr(prod, DA_SHIFT));
              end
            endcase
            if (col == 2'd3) begin
              col <= '0;
              row <= row + 2'd1;
            end else begin
              col <= col + 2'd1;
            end
          end
        end
        imupi_pkg::S_QMUL: begin
          if (mul_fin) begin
            p[p_tgt] <= p[p_tgt] + prod;
            idx      <= idx + 4'd1;
          end
        end
        imupi_pkg::S_NMAX: begin
          logic [63:0] a;
          a = p[idx[1:0]][63] ? 64'(-p[idx[1:0]]) : 64'(p[idx[1:0]]);
          if (a > mabs) mabs <= a;
          idx <= idx + 4'd1;
        end
        imupi_pkg::S_NSHIFT: begin
          ss <= '0;
          if (mabs[63:31] != '0) begin
            mabs <= mabs >> 1;
            for (int i = 0; i < 4; i++) p[i] <= p[i] >>> 1;
          end
        end
        imupi_pkg::S_NSQ: begin
          if (mul_fin) begin
            ss  <= ss + 64'(prod);
            idx <= idx + 4'd1;
          end
        end
        imupi_pkg::S_NCHK: begin
          srem <= ss;
          sres <= '0;
          sbit <= 64'd1 << 62;
          if (ss == '0) begin
            q[0] <= imupi_pkg::Q_ONE;
            q[1] <= '0;
            q[2] <= '0;
            q[3] <= '0;
          end
        end
        imupi_pkg::S_SQRT: begin
          if (srem >= sq_try) begin
            srem <= srem - sq_try;
            sres <= (sres >> 1) + sbit;
          end else begin
            sres <= sres >> 1;
          end
          sbit <= sbit >> 2;
          cnt  <= cnt + 6'd1;
        end
        imupi_pkg::S_DIV: begin
          if (!pend) begin
            logic [31:0] cmag;
            cmag = c_div[31] ? 32'(-c_div) : c_div;
            dneg <= c_div[31];
            dn   <= (62'(cmag) << 30) + 62'(sres[31:1]);
            drem <= '0;
            cnt  <= '0;
            pend <= 1'b1;
          end else if (cnt == 6'd62) begin
            q[idx[1:0]] <= imupi_pkg::clampq(dneg ? -$signed(64'(dn)) : $signed(64'(dn)));
            idx  <= idx + 4'd1;
            pend <= 1'b0;
          end else begin
            // restoring division, one quotient bit per cycle
            if (d_try >= {1'b0, sres[31:0]}) begin
              drem <= 32'(d_try - {1'b0, sres[31:0]});
              dn   <= {dn[60:0], 1'b1};
            end else begin
              drem <= d_try[31:0];
              dn   <= {dn[60:0], 1'b0};
            end
            cnt <= cnt + 6'd1;
          end
        end
        imupi_pkg::S_FIN: begin
          primed <= 1'b1;
          for (int i = 0; i < 3; i++) begin
            prate[i] <= rate_r[i];
            pwacc[i] <= wacc[i];
          end
        end
        imupi_pkg::S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            quat_w <= q[0];
            quat_x <= q[1];
            quat_y <= q[2];
            quat_z <= q[3];
            pos_x  <= pos[0];
            pos_y  <= pos[1];
            pos_z  <= pos[2];
            vel_x  <= vel[0];
            vel_y  <= vel[1];
            vel_z  <= vel[2];
          end
        end
        default: ;
      endcase

      if (state_next != state) begin
        idx  <= '0;
        row  <= '0;
        col  <= '0;
        cnt  <= '0;
        pend <= 1'b0;
      end
    end
  end

  `AST_IMP(a_mul_fin_idle, mul_fin, !mul_run, "multiplier finished while still running")
  `AST_IMP(a_norm_fits, state == imupi_pkg::S_NSQ, mabs[63:31] == '0,
           "normalising shift left a component too wide")
  `AST_IMP(a_quat_range, out_valid,
           (quat_w <= imupi_pkg::Q_ONE) && (quat_w >= -imupi_pkg::Q_ONE),
           "quaternion w out of unit range")
  `AST_NEXT(a_one_sample, in_valid && !in_stall, in_stall,
            "second sample taken before the first finished")

endmodule
`default_nettype wire

FILE: test/imu_midpoint_pose_integrator_tb.sv
// Testbench for the IMU midpoint pose integrator: directed and random samples checked against a local predictor.
`timescale 1ns / 1ps
module imu_midpoint_pose_integrator_tb;
  import imupi_pkg::*;

  localparam int FRAC = 16;
  localparam longint QONE = longint'(1) <<< 30;
  localparam longint GRAV = ((longint'(981) <<< FRAC) + 50) / 100;
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;
  localparam longint CYCLE_LIMIT = 40_000_000;

  typedef struct {
    logic signed [31:0] gyro[3];
    logic signed [31:0] accel[3];
    logic [23:0]        dt;
  } sample_t;

  typedef struct {
    logic signed [31:0] quat[4];
    logic signed [47:0] pos[3];
    logic signed [31:0] vel[3];
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = '0;
  logic [31:0] wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
  logic signed [31:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic [23:0] step_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] quat_w, quat_x, quat_y, quat_z;
  logic signed [47:0] pos_x, pos_y, pos_z;
  logic signed [31:0] vel_x, vel_y, vel_z;

  imu_midpoint_pose_integrator DUT (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .gyro_x(gyro_x), .gyro_y(gyro_y), .gyro_z(gyro_z),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z), .step_time(step_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  longint gyro_bias[3], accel_bias[3];
  longint att[4], pos[3], vel[3], prev_acc[3], prev_rate[3];
  bit primed;

  pose_t pose_q[$];
  int errors = 0;
  longint cycles = 0;
  bit quiet = 1'b0;
  int stall_left = 0;

  function automatic longint sat_w(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint clamp_unit(longint v);
    return v > QONE ? QONE : (v < -QONE ? -QONE : v);
  endfunction

  function automatic longint round_shr(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned res, b;
    res = 0;
    b = longint'(1) <<< 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint div_near(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic void renormalise(longint p[4]);
    longint unsigned m, a, ss;
    longint c[4];
    longint r;
    int s;
    m = 0;
    ss = 0;
    s = 0;
    for (int i = 0; i < 4; i++) begin
      a = p[i] < 0 ? -p[i] : p[i];
      if (a > m) m = a;
    end
    while ((m >> s) >= (longint'(1) <<< 31)) s++;
    for (int i = 0; i < 4; i++) begin
      c[i] = p[i] >>> s;
      ss += c[i] * c[i];
    end
    if (ss == 0) begin
      att = '{QONE, 0, 0, 0};
    end else begin
      r = int_sqrt(ss);
      for (int i = 0; i < 4; i++) att[i] = clamp_unit(div_near(c[i] * QONE, r));
    end
  endfunction

  function automatic pose_t integrate_sample(sample_t smp);
    longint rate[3], acc[3], wacc[3], rm[9], da[3], p[4];
    longint w, x, y, z, dt, dt2, sum, ma, mr;
    pose_t res;
    w = att[0]; x = att[1]; y = att[2]; z = att[3];
    dt = longint'(smp.dt);
    for (int i = 0; i < 3; i++) begin
      rate[i] = sat_w(longint'(smp.gyro[i]) - gyro_bias[i], 32);
      acc[i] = sat_w(longint'(smp.accel[i]) - accel_bias[i], 32);
    end
    rm[0] = (longint'(1) <<< 60) - 2 * (y * y + z * z);
    rm[1] = 2 * (x * y - w * z);
    rm[2] = 2 * (x * z + w * y);
    rm[3] = 2 * (x * y + w * z);
    rm[4] = (longint'(1) <<< 60) - 2 * (x * x + z * z);
    rm[5] = 2 * (y * z - w * x);
    rm[6] = 2 * (x * z - w * y);
    rm[7] = 2 * (y * z + w * x);
    rm[8] = (longint'(1) <<< 60) - 2 * (x * x + y * y);
    for (int i = 0; i < 9; i++) rm[i] = clamp_unit(round_shr(rm[i], 30));
    for (int i = 0; i < 3; i++) begin
      sum = 0;
      for (int j = 0; j < 3; j++) sum += round_shr(rm[i * 3 + j] * acc[j], 30);
      if (i == 2) sum += GRAV;
      wacc[i] = sat_w(sum, 32);
    end
    if (!primed) begin
      primed = 1'b1;
    end else begin
      dt2 = round_shr(dt * dt, 24);
      for (int i = 0; i < 3; i++) begin
        ma = (prev_acc[i] + wacc[i]) >>> 1;
        mr = (prev_rate[i] + rate[i]) >>> 1;
        pos[i] = sat_w(pos[i] + round_shr(dt * vel[i], 24) + round_shr(dt2 * ma, 25), 48);
        vel[i] = sat_w(vel[i] + round_shr(dt * ma, 24), 32);
        da[i] = sat_w(round_shr(dt * mr, FRAC - 5), 32);
      end
      p[0] = w * QONE - x * da[0] - y * da[1] - z * da[2];
      p[1] = w * da[0] + x * QONE + y * da[2] - z * da[1];
      p[2] = w * da[1] - x * da[2] + y * QONE + z * da[0];
      p[3] = w * da[2] + x * da[1] - y * da[0] + z * QONE;
      renormalise(p);
    end
    for (int i = 0; i < 3; i++) begin
      prev_rate[i] = rate[i];
      prev_acc[i] = wacc[i];
      res.pos[i] = pos[i][47:0];
      res.vel[i] = vel[i][31:0];
    end
    for (int i = 0; i < 4; i++) res.quat[i] = att[i][31:0];
    return res;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  // checks each result transfer against the oldest expected pose
  always @(posedge clk) begin
    pose_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("CHECKS FAILED");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (pose_q.size() == 0) begin
        $display("unexpected result transfer (cycle %0d)", cycles);
        errors++;
      end else begin
        e = pose_q.pop_front();
        if (quat_w !== e.quat[0]) report("quat_w", quat_w, e.quat[0]);
        if (quat_x !== e.quat[1]) report("quat_x", quat_x, e.quat[1]);
        if (quat_y !== e.quat[2]) report("quat_y", quat_y, e.quat[2]);
        if (quat_z !== e.quat[3]) report("quat_z", quat_z, e.quat[3]);
        if (pos_x !== e.pos[0]) report("pos_x", pos_x, e.pos[0]);
        if (pos_y !== e.pos[1]) report("pos_y", pos_y, e.pos[1]);
        if (pos_z !== e.pos[2]) report("pos_z", pos_z, e.pos[2]);
        if (vel_x !== e.vel[0]) report("vel_x", vel_x, e.vel[0]);
        if (vel_y !== e.vel[1]) report("vel_y", vel_y, e.vel[1]);
        if (vel_z !== e.vel[2]) report("vel_z", vel_z, e.vel[2]);
      end
      stall_left = quiet ? 0 : $urandom_range(0, 8);
    end
  end

  // receiver back-pressure, counted only while a result is offered
  always @(negedge clk) begin
    if (out_valid && stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_sample(sample_t smp);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    gyro_x = smp.gyro[0]; gyro_y = smp.gyro[1]; gyro_z = smp.gyro[2];
    accel_x = smp.accel[0]; accel_y = smp.accel[1]; accel_z = smp.accel[2];
    step_time = smp.dt;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    pose_q.push_back(integrate_sample(smp));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = val;
    @(negedge clk);
    wr_en = 1'b0;
    if (idx < 3) gyro_bias[idx] = longint'($signed(val));
    else if (idx < 6) accel_bias[idx - 3] = longint'($signed(val));
  endtask

  task automatic set_biases(logic [31:0] gx, gy, gz, ax, ay, az);
    write_reg(REG_GYRO_BIAS_X, gx);
    write_reg(REG_GYRO_BIAS_Y, gy);
    write_reg(REG_GYRO_BIAS_Z, gz);
    write_reg(REG_ACCEL_BIAS_X, ax);
    write_reg(REG_ACCEL_BIAS_Y, ay);
    write_reg(REG_ACCEL_BIAS_Z, az);
  endtask

  function automatic logic signed [31:0] near(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic sample_t make_sample(logic signed [31:0] g0, g1, g2,
                                          logic signed [31:0] a0, a1, a2,
                                          logic [23:0] dt);
    sample_t s;
    s.gyro = '{g0, g1, g2};
    s.accel = '{a0, a1, a2};
    s.dt = dt;
    return s;
  endfunction

  // mostly plausible motion, some full-range noise, rare extreme steps
  function automatic sample_t random_sample();
    sample_t s;
    int k;
    k = $urandom_range(0, 99);
    if (k < 80) begin
      s = make_sample(near(1 << 17), near(1 << 17), near(1 << 17),
                      near(20 << 16), near(20 << 16), -32'sd642908 + near(3 << 16),
                      $urandom_range(1000, 40000));
    end else if (k < 95) begin
      s = make_sample($urandom(), $urandom(), $urandom(),
                      $urandom(), $urandom(), $urandom(), $urandom());
    end else begin
      s = make_sample(near(1 << 20), near(1 << 20), near(1 << 20),
                      near(1 << 24), near(1 << 24), near(1 << 24),
                      ($urandom_range(0, 1) != 0) ? 24'hffffff : 24'h0);
    end
    return s;
  endfunction

  task automatic test_directed();
    // priming sample with extreme fields, then zero and extreme step times
    send_sample(make_sample(32'sh7fffffff, 32'sh80000000, 0,
                            32'sh80000000, 32'sh7fffffff, -32'sd642908, 24'd16777));
    send_sample(make_sample(1 << 16, 0, 0, 0, 0, -32'sd642908, 24'd0));
    send_sample(make_sample(1 << 16, -(1 << 15), 1 << 14, 1 << 16, 0, -32'sd642908, 24'd16777));
    send_sample(make_sample(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                            0, 0, 0, 24'hffffff));
    send_sample(make_sample(32'sh80000000, 32'sh80000000, 32'sh80000000,
                            32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 24'hffffff));
    send_sample(make_sample(32'sh80000000, 32'sh80000000, 32'sh80000000,
                            32'sh80000000, 32'sh80000000, 32'sh80000000, 24'hffffff));
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 24'd1));
    send_sample(make_sample(-1, -1, -1, -1, -1, -1, 24'h800000));
    drain();
  endtask

  task automatic test_bias_saturation();
    // subtraction saturates both ways
    set_biases(32'h7fffffff, 32'h80000000, 32'h7fffffff,
               32'h80000000, 32'h7fffffff, 32'h80000000);
    send_sample(make_sample(32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                            32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 24'd16777));
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 24'd40000));
    drain();
    // spare register indexes must leave the biases alone
    set_biases(32'h00001000, 32'hfffff000, 32'h00000800,
               32'h00010000, 32'hffff0000, 32'h00008000);
    write_reg(REG_SPARE_6, 32'h7fffffff);
    write_reg(REG_SPARE_7, 32'h80000000);
    send_sample(make_sample(1 << 12, 0, -(1 << 12), 1 << 16, 0, -32'sd642908, 24'd16777));
    send_sample(make_sample(0, 1 << 12, 0, 0, 1 << 16, -32'sd642908, 24'd16777));
    drain();
  endtask

  task automatic test_random_phase(int count);
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (n == count / 2) drain();  // sender holds off until every pose is back
      send_sample(random_sample());
    end
    quiet = 1'b0;
    drain();
  endtask

  initial begin
    gyro_bias = '{0, 0, 0};
    accel_bias = '{0, 0, 0};
    att = '{QONE, 0, 0, 0};
    pos = '{0, 0, 0};
    vel = '{0, 0, 0};
    prev_acc = '{0, 0, 0};
    prev_rate = '{0, 0, 0};
    primed = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_bias_saturation();
    set_biases(0, 0, 0, 0, 0, 0);
    test_random_phase(450);
    set_biases(near(1 << 12), near(1 << 12), near(1 << 12),
               near(1 << 15), near(1 << 15), near(1 << 15));
    test_random_phase(450);
    set_biases($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    test_random_phase(450);
    set_biases(32'h80000000, 32'h80000000, 32'h80000000,
               32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    test_random_phase(150);
    set_biases(near(1 << 10), near(1 << 10), near(1 << 10),
               near(1 << 14), near(1 << 14), near(1 << 14));
    test_random_phase(320);
    repeat (100) @(posedge clk);
    if (errors == 0 && pose_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/imupi_pkg.sv
hdl/imu_midpoint_pose_integrator.sv
test/imu_midpoint_pose_integrator_tb.sv
